// ----- sv/npc_pkg.sv -----
// Package for the nearest palette color matcher: types, palette table, min helper.
`timescale 1ns / 1ps
`default_nettype none

package npc_pkg;

  localparam int NPC_CH_W     = 8;
  localparam int NPC_IDX_W    = 4;
  localparam int NPC_ENTRIES  = 16;
  localparam int NPC_CHANNELS = 3;
  localparam int NPC_LEVELS   = 4;
  localparam int NPC_SQ_W     = 2 * NPC_CH_W;
  localparam int NPC_DIST_W   = NPC_SQ_W + 2;

  typedef logic [NPC_CH_W-1:0]   chan_t;
  typedef logic [NPC_IDX_W-1:0]  idx_t;
  typedef logic [NPC_SQ_W-1:0]   sq_t;
  typedef logic [NPC_DIST_W-1:0] dist_t;
  typedef logic [1:0]            lvl_t;

  typedef struct packed {
    dist_t dsum;
    idx_t  idx;
  } cand_t;

  // Every palette channel takes one of four levels.
  localparam chan_t NPC_LEVEL [NPC_LEVELS] = '{8'd0, 8'd128, 8'd192, 8'd255};

  // Palette as level codes: {red, green, blue}.
  localparam lvl_t NPC_PAL [NPC_ENTRIES][NPC_CHANNELS] = '{
    '{2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd1}, '{2'd0, 2'd1, 2'd0}, '{2'd0, 2'd1, 2'd1},
    '{2'd1, 2'd0, 2'd0}, '{2'd1, 2'd0, 2'd1}, '{2'd1, 2'd1, 2'd0}, '{2'd2, 2'd2, 2'd2},
    '{2'd1, 2'd1, 2'd1}, '{2'd0, 2'd0, 2'd3}, '{2'd0, 2'd3, 2'd0}, '{2'd0, 2'd3, 2'd3},
    '{2'd3, 2'd0, 2'd0}, '{2'd3, 2'd0, 2'd3}, '{2'd3, 2'd3, 2'd0}, '{2'd3, 2'd3, 2'd3}
  };

  // a is the lower index; b wins only when strictly nearer.
  function automatic cand_t npc_min(cand_t a, cand_t b);
    return (b.dsum < a.dsum) ? b : a;
  endfunction

endpackage

`default_nettype wire

// ----- sv/npc_pix_if.sv -----
// Input channel: one color word as three 8-bit channels.
`timescale 1ns / 1ps
`default_nettype none

interface npc_pix_if
  import npc_pkg::*;
();
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- sv/npc_idx_if.sv -----
// Output channel: one palette index word.
`timescale 1ns / 1ps
`default_nettype none

interface npc_idx_if
  import npc_pkg::*;
();
  logic valid;
  logic ready;
  idx_t palette_index;

  modport source (output valid, output palette_index, input ready);
  modport sink   (input valid, input palette_index, output ready);
endinterface

`default_nettype wire

// ----- sv/nearest_palette_color_16_core.sv -----
// Nearest palette color matcher: four-stage pipeline from color word to palette index.
//
// Takes one color word per clock, unless an output stall has filled the pipeline, and returns
// the index of the nearest of the 16 fixed palette entries by squared distance, lowest index
// on ties. Throughput is one word per cycle while the output is not stalled. Stage one
// squares the channel distance to each of the four palette levels, stage two sums those
// squares into the 16 entry distances, stage three reduces them to four by a two-level
// compare tree, stage four reduces those to one and is the output register. Each stage
// holds its own valid bit and takes a new word whenever it is empty or its successor moves,
// so bubbles are squeezed out during an output stall.
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_16_core
  import npc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  npc_pix_if.sink    pix_i,
  npc_idx_if.source  idx_o
);

  localparam int GROUPS = NPC_ENTRIES / 4;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  sq_t   sq_d   [NPC_CHANNELS][NPC_LEVELS];
  sq_t   sq_q   [NPC_CHANNELS][NPC_LEVELS];
  dist_t dist_d [NPC_ENTRIES];
  dist_t dist_q [NPC_ENTRIES];
  cand_t grp_d  [GROUPS];
  cand_t grp_q  [GROUPS];
  cand_t best_d;
  idx_t  idx_q;
  chan_t ch     [NPC_CHANNELS];

  assign rdy4 = !v4_q || idx_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign pix_i.ready = rdy1;

  assign ch[0] = pix_i.red;
  assign ch[1] = pix_i.green;
  assign ch[2] = pix_i.blue;

  always_comb begin
    chan_t diff;
    for (int c = 0; c < NPC_CHANNELS; c++) begin
      for (int l = 0; l < NPC_LEVELS; l++) begin
        diff = (ch[c] >= NPC_LEVEL[l]) ? (ch[c] - NPC_LEVEL[l]) : (NPC_LEVEL[l] - ch[c]);
        sq_d[c][l] = sq_t'(diff) * sq_t'(diff);
      end
    end
  end

  always_comb begin
    for (int e = 0; e < NPC_ENTRIES; e++) begin
      dist_d[e] = dist_t'(sq_q[0][NPC_PAL[e][0]])
                + dist_t'(sq_q[1][NPC_PAL[e][1]])
                + dist_t'(sq_q[2][NPC_PAL[e][2]]);
    end
  end

  always_comb begin
    cand_t c0, c1, c2, c3;
    for (int g = 0; g < GROUPS; g++) begin
      c0 = '{dsum: dist_q[4*g],     idx: NPC_IDX_W'(4*g)};
      c1 = '{dsum: dist_q[4*g + 1], idx: NPC_IDX_W'(4*g + 1)};
      c2 = '{dsum: dist_q[4*g + 2], idx: NPC_IDX_W'(4*g + 2)};
      c3 = '{dsum: dist_q[4*g + 3], idx: NPC_IDX_W'(4*g + 3)};
      grp_d[g] = npc_min(npc_min(c0, c1), npc_min(c2, c3));
    end
  end

  assign best_d = npc_min(npc_min(grp_q[0], grp_q[1]), npc_min(grp_q[2], grp_q[3]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pix_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && pix_i.valid) sq_q   <= sq_d;
    if (rdy2 && v1_q)        dist_q <= dist_d;
    if (rdy3 && v2_q)        grp_q  <= grp_d;
    if (rdy4 && v3_q)        idx_q  <= best_d.idx;
  end

  assign idx_o.valid         = v4_q;
  assign idx_o.palette_index = idx_q;

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> v1_q)
    else $error("accepted word did not reach stage one");

  a_out_from_s3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v4_q) |-> $past(v3_q))
    else $error("result appeared without a word in stage three");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |=> (v1_q && $stable(sq_q[0][0]) && $stable(sq_q[2][3])))
    else $error("stage one lost its word during a stall");

  a_s3_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !rdy4) |=> (v3_q && $stable(grp_q[0]) && $stable(grp_q[3])))
    else $error("stage three lost its word during a stall");

endmodule

`default_nettype wire
